FILE: src/acwm_pkg.sv
// shared types, field widths and default parameters of the capture block
`default_nettype none

package acwm_pkg;

  // default sizing
  localparam int unsigned MAX_FRAMES_DEF   = 1048576;
  localparam int unsigned WAVE_STRIDE_DEF  = 128;
  localparam int unsigned WAVE_COLUMNS_DEF = 128;

  // input field widths
  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned SAMPLE_W  = 25;
  localparam int unsigned S_TDATA_W = 56;

  // result field widths
  localparam int unsigned PCM_W       = 16;
  localparam int unsigned ADDR_W      = 20;
  localparam int unsigned POSITION_W  = 21;
  localparam int unsigned COLUMN_W    = 7;
  localparam int unsigned GEN_W       = 32;
  localparam int unsigned M_TDATA_W   = 152;
  localparam int unsigned M_TDATA_USE = 151;

  // fixed-point scale of the input samples
  localparam int unsigned FULL_SCALE_LOG2 = 23;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2
  } acwm_op_e;

  // one classified item as it travels from front to back
  typedef struct packed {
    acwm_op_e                op;
    logic signed [PCM_W-1:0] line_pcm;
    logic signed [PCM_W-1:0] mic_pcm;
    logic                    block_last;
  } acwm_item_t;

endpackage

`default_nettype wire

FILE: src/audio_capture_with_waveform_minmax.sv
// pcm capture with min/max waveform preview: top level
// path: an accepted input beat passes the front register, a queue entry and the
// result register on its way to its result beat
// throughput: one item per cycle; each side may stall independently
// reset: asynchronous, active low; capture idle, counts and source select zero
// no clearing pass: the preview only ever reports the current column's min/max
`default_nettype none

module audio_capture_with_waveform_minmax
  import acwm_pkg::*;
#(
  parameter int unsigned MAX_FRAMES   = MAX_FRAMES_DEF,
  parameter int unsigned WAVE_STRIDE  = WAVE_STRIDE_DEF,
  parameter int unsigned WAVE_COLUMNS = WAVE_COLUMNS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic                 cfg_data_i,     // source_select
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,   // sample_line, sample_mic
  input  wire logic [OPCODE_W-1:0]  s_axis_tuser,   // opcode
  input  wire logic                 s_axis_tlast,   // block_last
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // write_address, write_data, capture_active, position, captured_length,
  // column, column_min, column_max, live_generation, stopped_full
  output logic [M_TDATA_W-1:0]      m_axis_tdata,
  output logic                      m_axis_tuser    // write_enable
);

  logic       source_select_q, source_select_d;
  logic       push, push_ready;
  acwm_item_t front_item, queue_item;
  logic       queue_valid, pop;

  assign cfg_ready_o     = 1'b1;
  assign source_select_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : source_select_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_select_q <= 1'b0;
    end else begin
      source_select_q <= source_select_d;
    end
  end

  acwm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .push_o       (push),
    .item_o       (front_item),
    .push_ready_i (push_ready)
  );

  acwm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .ready_o(push_ready),
    .valid_o(queue_valid),
    .item_o (queue_item),
    .pop_i  (pop)
  );

  acwm_back #(
    .MAX_FRAMES  (MAX_FRAMES),
    .WAVE_STRIDE (WAVE_STRIDE),
    .WAVE_COLUMNS(WAVE_COLUMNS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (queue_valid),
    .item_i         (queue_item),
    .pop_o          (pop),
    .source_select_i(source_select_q),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser)
  );

endmodule

`default_nettype wire

FILE: src/acwm_front.sv
// front end: takes input beats, converts both sources to 16-bit pcm
`default_nettype none

module acwm_front
  import acwm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // sample_line, sample_mic
  input  wire logic [OPCODE_W-1:0]  s_axis_tuser,  // opcode
  input  wire logic                 s_axis_tlast,  // block_last
  output logic                      push_o,
  output acwm_item_t                item_o,
  input  wire logic                 push_ready_i
);

  // clamp to +-1.0 and scale by 32767, quotient truncated toward zero
  function automatic logic signed [PCM_W-1:0] to_pcm(input logic signed [SAMPLE_W-1:0] s);
    logic                              neg;
    logic [SAMPLE_W-1:0]               mag_full;
    logic [FULL_SCALE_LOG2:0]          mag;
    logic [FULL_SCALE_LOG2+PCM_W-1:0]  prod;
    logic [PCM_W-1:0]                  q;
    neg      = s[SAMPLE_W-1];
    mag_full = neg ? (~s + 1'b1) : s;
    if (mag_full > SAMPLE_W'(1 << FULL_SCALE_LOG2)) begin
      mag = (FULL_SCALE_LOG2+1)'(1 << FULL_SCALE_LOG2);
    end else begin
      mag = mag_full[FULL_SCALE_LOG2:0];
    end
    // x * 32767 as (x << 15) - x
    prod = ({(FULL_SCALE_LOG2+PCM_W)'(mag)} << (PCM_W - 1))
         - (FULL_SCALE_LOG2+PCM_W)'(mag);
    q    = prod[FULL_SCALE_LOG2+PCM_W-1:FULL_SCALE_LOG2];
    return neg ? $signed(-q) : $signed(q);
  endfunction

  logic       valid_q, valid_d;
  acwm_item_t item_q, item_d;
  logic       accept;

  assign s_axis_tready = !valid_q || push_ready_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (accept) begin
      valid_d           = 1'b1;
      item_d.op         = acwm_op_e'(s_axis_tuser);
      item_d.line_pcm   = to_pcm(s_axis_tdata[SAMPLE_W-1:0]);
      item_d.mic_pcm    = to_pcm(s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]);
      item_d.block_last = s_axis_tlast;
    end else if (push_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign push_o = valid_q;
  assign item_o = item_q;

endmodule

`default_nettype wire

FILE: src/acwm_queue.sv
// short fifo of classified items between front and back
`default_nettype none

module acwm_queue
  import acwm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire acwm_item_t item_i,
  output logic            ready_o,
  output logic            valid_o,
  output acwm_item_t      item_o,
  input  wire logic       pop_i
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  acwm_item_t       entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = entry_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/acwm_back.sv
// back end: capture state, preview min/max and the registered result beat
`default_nettype none

module acwm_back
  import acwm_pkg::*;
#(
  parameter int unsigned MAX_FRAMES   = MAX_FRAMES_DEF,
  parameter int unsigned WAVE_STRIDE  = WAVE_STRIDE_DEF,
  parameter int unsigned WAVE_COLUMNS = WAVE_COLUMNS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 item_valid_i,
  input  wire acwm_item_t           item_i,
  output logic                      pop_o,
  input  wire logic                 source_select_i,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // write_address, write_data, capture_active, position, captured_length,
  // column, column_min, column_max, live_generation, stopped_full
  output logic [M_TDATA_W-1:0]      m_axis_tdata,
  output logic                      m_axis_tuser   // write_enable
);

  localparam int unsigned POS_W = $clog2(MAX_FRAMES + 1);
  localparam int unsigned STR_W = (WAVE_STRIDE > 1) ? $clog2(WAVE_STRIDE) : 1;
  localparam int unsigned COL_W = $clog2(WAVE_COLUMNS);

  // capture state
  logic                    cap_q, cap_d;
  logic                    src_q, src_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic [POS_W-1:0]        len_q, len_d;
  logic [STR_W-1:0]        stride_q, stride_d;
  logic [COL_W-1:0]        col_q, col_d;
  logic signed [PCM_W-1:0] min_q, min_d;
  logic signed [PCM_W-1:0] max_q, max_d;
  logic [GEN_W-1:0]        gen_q, gen_d;
  logic                    saw_q, saw_d;

  // result register
  logic                    out_valid_q, out_valid_d;
  logic [M_TDATA_W-1:0]    out_data_q, out_data_d;
  logic                    out_we_q, out_we_d;

  // per-item working values
  logic                    pop;
  logic                    saw_blk;
  logic                    new_col;
  logic signed [PCM_W-1:0] pcm;
  logic                    res_we, res_full;
  logic [ADDR_W-1:0]       res_addr;
  logic signed [PCM_W-1:0] res_data, res_min, res_max;
  logic [COLUMN_W-1:0]     res_col;

  assign pop   = item_valid_i && (!out_valid_q || m_axis_tready);
  assign pop_o = pop;

  assign pcm     = src_q ? item_i.mic_pcm : item_i.line_pcm;
  // the preview column changes exactly when the stride count wraps to zero
  assign new_col = (stride_q == '0);

  always_comb begin
    cap_d    = cap_q;
    src_d    = src_q;
    pos_d    = pos_q;
    len_d    = len_q;
    stride_d = stride_q;
    col_d    = col_q;
    min_d    = min_q;
    max_d    = max_q;
    gen_d    = gen_q;
    saw_d    = saw_q;
    saw_blk  = saw_q;
    res_we   = 1'b0;
    res_full = 1'b0;
    res_addr = '0;
    res_data = '0;
    res_min  = '0;
    res_max  = '0;
    res_col  = '0;
    if (pop) begin
      case (item_i.op)
        OP_START: begin
          src_d    = source_select_i;
          cap_d    = 1'b1;
          pos_d    = '0;
          len_d    = '0;
          stride_d = '0;
          col_d    = '0;
        end
        OP_STOP: begin
          if (cap_q) begin
            cap_d = 1'b0;
            len_d = pos_q;
          end
        end
        OP_SAMPLE: begin
          if (cap_q) begin
            saw_blk = 1'b1;
            if (pos_q >= POS_W'(MAX_FRAMES)) begin
              cap_d    = 1'b0;
              len_d    = pos_q;
              res_full = 1'b1;
            end else begin
              if (new_col) begin
                min_d = pcm;
                max_d = pcm;
              end else begin
                min_d = (pcm < min_q) ? pcm : min_q;
                max_d = (pcm > max_q) ? pcm : max_q;
              end
              res_we   = 1'b1;
              res_addr = ADDR_W'(pos_q);
              res_data = pcm;
              res_col  = COLUMN_W'(col_q);
              res_min  = min_d;
              res_max  = max_d;
              pos_d    = pos_q + 1'b1;
              if (stride_q == STR_W'(WAVE_STRIDE - 1)) begin
                stride_d = '0;
                col_d    = (col_q == COL_W'(WAVE_COLUMNS - 1)) ? '0 : col_q + 1'b1;
              end else begin
                stride_d = stride_q + 1'b1;
              end
            end
          end
          if (item_i.block_last) begin
            if (saw_blk) begin
              gen_d = gen_q + 1'b1;
            end
            saw_d = 1'b0;
          end else begin
            saw_d = saw_blk;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_we_d    = out_we_q;
    if (pop) begin
      out_valid_d = 1'b1;
      out_we_d    = res_we;
      out_data_d  = {{(M_TDATA_W - M_TDATA_USE){1'b0}},
                     res_full,
                     gen_d,
                     res_max,
                     res_min,
                     res_col,
                     POSITION_W'(len_d),
                     POSITION_W'(pos_d),
                     cap_d,
                     res_data,
                     res_addr};
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= 1'b0;
      src_q       <= 1'b0;
      pos_q       <= '0;
      len_q       <= '0;
      stride_q    <= '0;
      col_q       <= '0;
      min_q       <= '0;
      max_q       <= '0;
      gen_q       <= '0;
      saw_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q       <= cap_d;
      src_q       <= src_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      stride_q    <= stride_d;
      col_q       <= col_d;
      min_q       <= min_d;
      max_q       <= max_d;
      gen_q       <= gen_d;
      saw_q       <= saw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_we_q   <= out_we_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_we_q;

  // write position never runs past the buffer
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_W'(MAX_FRAMES))
    else $error("write position beyond buffer size");

  // a written sample lies within the reported column range
  a_minmax_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && res_we) |-> (res_min <= res_data && res_data <= res_max))
    else $error("column min/max do not bracket the written sample");

  // a full buffer ends the capture and writes nothing
  a_full_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && res_full) |=> (!cap_q && out_valid_q && !out_we_q))
    else $error("full buffer did not end capture cleanly");

  // a write only happens while a capture runs
  a_write_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && res_we) |-> (cap_q && cap_d))
    else $error("sample written while capture idle");

  // the preview column stays inside the column count
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= COL_W'(WAVE_COLUMNS - 1))
    else $error("preview column out of range");

endmodule

`default_nettype wire
